>>> src/sdcg_pkg.sv
package sdcg_pkg;

    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned ROW_W    = 24;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRIDED_MODE     = 3'd0,
        CFG_SOURCE_ROW_BYTES = 3'd1,
        CFG_DEST_ROW_BYTES   = 3'd2,
        CFG_SOURCE_PITCH     = 3'd3,
        CFG_DEST_PITCH       = 3'd4
    } cfg_index_t;

    localparam logic [ROW_W-1:0] ROW_BYTES_RESET = ROW_W'(1);

endpackage

>>> src/strided_dma_chunk_generator.sv
// channel | handshake         | payload
// --------+-------------------+---------------------------------------------------
// in      | in_valid/in_stall | op, source_base, dest_base, total_bytes
// out     | out_valid/out_stall | chunk_source, chunk_dest, chunk_bytes,
//         |                   | final_chunk, idle_flag
// cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one item per cycle while out_stall does not hold the result register: the chunk
// length, cursor and offset updates are done on the item in the input register and
// land in the result register. result valid once the item has passed the input
// register and the result register; start items give no result.
// rst_n clears the transfer state and loads the register defaults.
// out_stall holds the result register; the input register then holds a next item
// and in_stall rises, while start items keep draining. cfg_ready is always high.
module strided_dma_chunk_generator
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                op,
    input  logic [sdcg_pkg::ADDR_W-1:0]         source_base,
    input  logic [sdcg_pkg::ADDR_W-1:0]         dest_base,
    input  logic [sdcg_pkg::ADDR_W-1:0]         total_bytes,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sdcg_pkg::ADDR_W-1:0]         chunk_source,
    output logic [sdcg_pkg::ADDR_W-1:0]         chunk_dest,
    output logic [sdcg_pkg::ADDR_W-1:0]         chunk_bytes,
    output logic                                final_chunk,
    output logic                                idle_flag,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sdcg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sdcg_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned AW = sdcg_pkg::ADDR_W;
    localparam int unsigned RW = sdcg_pkg::ROW_W;

    // configuration
    logic          strided_mode_reg;
    logic [RW-1:0] source_row_bytes_reg;
    logic [RW-1:0] dest_row_bytes_reg;
    logic [AW-1:0] source_pitch_reg;
    logic [AW-1:0] dest_pitch_reg;

    // transfer state
    logic [AW-1:0] source_cursor_reg, source_cursor_next;
    logic [AW-1:0] dest_cursor_reg, dest_cursor_next;
    logic [RW-1:0] source_row_offset_reg, source_row_offset_next;
    logic [RW-1:0] dest_row_offset_reg, dest_row_offset_next;
    logic [AW-1:0] bytes_remaining_reg, bytes_remaining_next;

    // input register
    logic          in_valid_reg;
    logic          in_op_reg;
    logic [AW-1:0] in_source_reg;
    logic [AW-1:0] in_dest_reg;
    logic [AW-1:0] in_total_reg;

    // result register
    logic          out_valid_reg;
    logic [AW-1:0] chunk_source_reg, chunk_source_next;
    logic [AW-1:0] chunk_dest_reg, chunk_dest_next;
    logic [AW-1:0] chunk_bytes_reg, chunk_bytes_next;
    logic          final_chunk_reg, final_chunk_next;
    logic          idle_flag_reg, idle_flag_next;

    logic          out_free;
    logic          advance;
    logic          in_take;

    logic [RW-1:0] sw, dw, so, dof, srem, drem, rowmin;
    logic [RW:0]   so_sum, dof_sum;
    logic          src_row_done, dst_row_done;
    logic [AW-1:0] chunk;
    logic [AW-1:0] src_after, dst_after, src_skip, dst_skip;

    assign cfg_ready = 1'b1;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && ((in_op_reg == sdcg_pkg::OP_START) || out_free);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strided_mode_reg     <= 1'b0;
            source_row_bytes_reg <= sdcg_pkg::ROW_BYTES_RESET;
            dest_row_bytes_reg   <= sdcg_pkg::ROW_BYTES_RESET;
            source_pitch_reg     <= '0;
            dest_pitch_reg       <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sdcg_pkg::CFG_STRIDED_MODE:     strided_mode_reg     <= cfg_data[0];
                sdcg_pkg::CFG_SOURCE_ROW_BYTES: source_row_bytes_reg <= cfg_data[RW-1:0];
                sdcg_pkg::CFG_DEST_ROW_BYTES:   dest_row_bytes_reg   <= cfg_data[RW-1:0];
                sdcg_pkg::CFG_SOURCE_PITCH:     source_pitch_reg     <= cfg_data[AW-1:0];
                sdcg_pkg::CFG_DEST_PITCH:       dest_pitch_reg       <= cfg_data[AW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // chunk computation
    always_comb
    begin
        sw  = (source_row_bytes_reg == '0) ? RW'(1) : source_row_bytes_reg;
        dw  = (dest_row_bytes_reg == '0) ? RW'(1) : dest_row_bytes_reg;
        so  = (source_row_offset_reg < sw) ? source_row_offset_reg : '0;
        dof = (dest_row_offset_reg < dw) ? dest_row_offset_reg : '0;
        srem   = sw - so;
        drem   = dw - dof;
        rowmin = (srem < drem) ? srem : drem;

        if (strided_mode_reg)
            chunk = ({{(AW-RW){1'b0}}, rowmin} < bytes_remaining_reg)
                  ? {{(AW-RW){1'b0}}, rowmin} : bytes_remaining_reg;
        else
            chunk = bytes_remaining_reg;

        so_sum  = {1'b0, so} + chunk[RW:0];
        dof_sum = {1'b0, dof} + chunk[RW:0];
        src_row_done = (so_sum == {1'b0, sw});
        dst_row_done = (dof_sum == {1'b0, dw});

        src_after = source_cursor_reg + chunk;
        dst_after = dest_cursor_reg + chunk;
        src_skip  = source_pitch_reg - {{(AW-RW){1'b0}}, sw};
        dst_skip  = dest_pitch_reg - {{(AW-RW){1'b0}}, dw};

        source_cursor_next     = source_cursor_reg;
        dest_cursor_next       = dest_cursor_reg;
        source_row_offset_next = source_row_offset_reg;
        dest_row_offset_next   = dest_row_offset_reg;
        bytes_remaining_next   = bytes_remaining_reg;

        chunk_source_next = '0;
        chunk_dest_next   = '0;
        chunk_bytes_next  = '0;
        final_chunk_next  = 1'b0;
        idle_flag_next    = 1'b1;

        if (in_op_reg == sdcg_pkg::OP_START)
        begin
            source_cursor_next     = in_source_reg;
            dest_cursor_next       = in_dest_reg;
            bytes_remaining_next   = in_total_reg;
            source_row_offset_next = '0;
            dest_row_offset_next   = '0;
        end
        else if (bytes_remaining_reg != '0)
        begin
            chunk_source_next    = source_cursor_reg;
            chunk_dest_next      = dest_cursor_reg;
            chunk_bytes_next     = chunk;
            bytes_remaining_next = bytes_remaining_reg - chunk;
            final_chunk_next     = (bytes_remaining_reg == chunk);
            idle_flag_next       = 1'b0;
            if (strided_mode_reg)
            begin
                source_cursor_next     = src_row_done ? src_after + src_skip : src_after;
                dest_cursor_next       = dst_row_done ? dst_after + dst_skip : dst_after;
                source_row_offset_next = src_row_done ? '0 : so_sum[RW-1:0];
                dest_row_offset_next   = dst_row_done ? '0 : dof_sum[RW-1:0];
            end
            else
            begin
                source_cursor_next = src_after;
                dest_cursor_next   = dst_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_cursor_reg     <= '0;
            dest_cursor_reg       <= '0;
            source_row_offset_reg <= '0;
            dest_row_offset_reg   <= '0;
            bytes_remaining_reg   <= '0;
        end
        else if (advance)
        begin
            source_cursor_reg     <= source_cursor_next;
            dest_cursor_reg       <= dest_cursor_next;
            source_row_offset_reg <= source_row_offset_next;
            dest_row_offset_reg   <= dest_row_offset_next;
            bytes_remaining_reg   <= bytes_remaining_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg     <= op;
            in_source_reg <= source_base;
            in_dest_reg   <= dest_base;
            in_total_reg  <= total_bytes;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && (in_op_reg == sdcg_pkg::OP_NEXT))
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && (in_op_reg == sdcg_pkg::OP_NEXT))
        begin
            chunk_source_reg <= chunk_source_next;
            chunk_dest_reg   <= chunk_dest_next;
            chunk_bytes_reg  <= chunk_bytes_next;
            final_chunk_reg  <= final_chunk_next;
            idle_flag_reg    <= idle_flag_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign chunk_source = chunk_source_reg;
    assign chunk_dest   = chunk_dest_reg;
    assign chunk_bytes  = chunk_bytes_reg;
    assign final_chunk  = final_chunk_reg;
    assign idle_flag    = idle_flag_reg;

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int QUIET_LIMIT = 1000;
    localparam logic [sdcg_pkg::CFG_IDX_W-1:0] CFG_SPARE_INDEX = 3'd7;

    typedef struct {
        logic [sdcg_pkg::ADDR_W-1:0] src_addr;
        logic [sdcg_pkg::ADDR_W-1:0] dst_addr;
        logic [sdcg_pkg::ADDR_W-1:0] len;
        logic                        last;
        logic                        idle;
    } chunk_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic                            op;
    logic [sdcg_pkg::ADDR_W-1:0]     source_base;
    logic [sdcg_pkg::ADDR_W-1:0]     dest_base;
    logic [sdcg_pkg::ADDR_W-1:0]     total_bytes;
    logic                            out_valid;
    logic                            out_stall;
    logic [sdcg_pkg::ADDR_W-1:0]     chunk_source;
    logic [sdcg_pkg::ADDR_W-1:0]     chunk_dest;
    logic [sdcg_pkg::ADDR_W-1:0]     chunk_bytes;
    logic                            final_chunk;
    logic                            idle_flag;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [sdcg_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sdcg_pkg::CFG_DATA_W-1:0] cfg_data;

    // predictor copy of the registers and the transfer state
    logic                            cfg_strided = 1'b0;
    logic [sdcg_pkg::ROW_W-1:0]      src_width   = sdcg_pkg::ROW_BYTES_RESET;
    logic [sdcg_pkg::ROW_W-1:0]      dst_width   = sdcg_pkg::ROW_BYTES_RESET;
    logic [sdcg_pkg::ADDR_W-1:0]     src_stride  = '0;
    logic [sdcg_pkg::ADDR_W-1:0]     dst_stride  = '0;
    logic [sdcg_pkg::ADDR_W-1:0]     src_ptr     = '0;
    logic [sdcg_pkg::ADDR_W-1:0]     dst_ptr     = '0;
    logic [sdcg_pkg::ROW_W-1:0]      src_col     = '0;
    logic [sdcg_pkg::ROW_W-1:0]      dst_col     = '0;
    logic [sdcg_pkg::ADDR_W-1:0]     bytes_left  = '0;

    chunk_t pending_chunks[$];
    int     error_count  = 0;
    int     quiet_cycles = 0;
    bit     idle_on      = 1'b1;

    strided_dma_chunk_generator i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .source_base  (source_base),
        .dest_base    (dest_base),
        .total_bytes  (total_bytes),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .chunk_source (chunk_source),
        .chunk_dest   (chunk_dest),
        .chunk_bytes  (chunk_bytes),
        .final_chunk  (final_chunk),
        .idle_flag    (idle_flag),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report(input string what);
        if (error_count < 40)
        begin
            $display("error at %0t: %s", $time, what);
        end
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [sdcg_pkg::ADDR_W-1:0] got,
                               input logic [sdcg_pkg::ADDR_W-1:0] want);
        if (got !== want)
        begin
            report($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    task automatic predict_chunk(input logic op_i, input logic [sdcg_pkg::ADDR_W-1:0] sb,
                                 input logic [sdcg_pkg::ADDR_W-1:0] db,
                                 input logic [sdcg_pkg::ADDR_W-1:0] nb);
        logic [sdcg_pkg::ADDR_W-1:0] sw;
        logic [sdcg_pkg::ADDR_W-1:0] dw;
        logic [sdcg_pkg::ADDR_W-1:0] so;
        logic [sdcg_pkg::ADDR_W-1:0] dof;
        logic [sdcg_pkg::ADDR_W-1:0] len;
        chunk_t c;
        if (op_i == sdcg_pkg::OP_START)
        begin
            src_ptr    = sb;
            dst_ptr    = db;
            bytes_left = nb;
            src_col    = '0;
            dst_col    = '0;
        end
        else
        begin
            c.src_addr = '0;
            c.dst_addr = '0;
            c.len      = '0;
            c.last     = 1'b0;
            c.idle     = 1'b1;
            if (bytes_left != 0)
            begin
                c.src_addr = src_ptr;
                c.dst_addr = dst_ptr;
                c.idle     = 1'b0;
                if (!cfg_strided)
                begin
                    len     = bytes_left;
                    src_ptr = src_ptr + len;
                    dst_ptr = dst_ptr + len;
                end
                else
                begin
                    sw  = (src_width == 0) ? 32'd1 : 32'(src_width);
                    dw  = (dst_width == 0) ? 32'd1 : 32'(dst_width);
                    // an offset left past a shrunk row restarts the row
                    so  = (32'(src_col) < sw) ? 32'(src_col) : 32'd0;
                    dof = (32'(dst_col) < dw) ? 32'(dst_col) : 32'd0;
                    len = (sw - so < dw - dof) ? sw - so : dw - dof;
                    if (bytes_left < len)
                    begin
                        len = bytes_left;
                    end
                    src_ptr = src_ptr + len;
                    dst_ptr = dst_ptr + len;
                    so      = so + len;
                    dof     = dof + len;
                    if (so == sw)
                    begin
                        so      = '0;
                        src_ptr = src_ptr + src_stride - sw;
                    end
                    if (dof == dw)
                    begin
                        dof     = '0;
                        dst_ptr = dst_ptr + dst_stride - dw;
                    end
                    src_col = so[sdcg_pkg::ROW_W-1:0];
                    dst_col = dof[sdcg_pkg::ROW_W-1:0];
                end
                bytes_left = bytes_left - len;
                c.len      = len;
                c.last     = (bytes_left == 0);
            end
            pending_chunks.push_back(c);
        end
    endtask

    task automatic send_item(input logic op_i, input logic [sdcg_pkg::ADDR_W-1:0] sb,
                             input logic [sdcg_pkg::ADDR_W-1:0] db,
                             input logic [sdcg_pkg::ADDR_W-1:0] nb);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= op_i;
        source_base <= sb;
        dest_base   <= db;
        total_bytes <= nb;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        predict_chunk(op_i, sb, db, nb);
    endtask

    task automatic next_chunk();
        send_item(sdcg_pkg::OP_NEXT, $urandom, $urandom, $urandom);
    endtask

    task automatic write_reg(input logic [sdcg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sdcg_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            sdcg_pkg::CFG_STRIDED_MODE:     cfg_strided = data[0];
            sdcg_pkg::CFG_SOURCE_ROW_BYTES: src_width   = data[sdcg_pkg::ROW_W-1:0];
            sdcg_pkg::CFG_DEST_ROW_BYTES:   dst_width   = data[sdcg_pkg::ROW_W-1:0];
            sdcg_pkg::CFG_SOURCE_PITCH:     src_stride  = data;
            sdcg_pkg::CFG_DEST_PITCH:       dst_stride  = data;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_chunks.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [sdcg_pkg::ADDR_W-1:0] rand_addr();
        case ($urandom_range(0, 3))
            0:       return 32'hFFFF_FFFF - $urandom_range(0, 63);
            1:       return $urandom_range(0, 63);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [sdcg_pkg::CFG_DATA_W-1:0] rand_width();
        logic [7:0] upper;
        upper = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0:       return {upper, 24'd0};
            1:       return {upper, 24'hFF_FFFF};
            2:       return $urandom;
            default: return {upper, 24'($urandom_range(1, 16))};
        endcase
    endfunction

    function automatic logic [sdcg_pkg::CFG_DATA_W-1:0] rand_pitch();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            3:       return 32'hFFFF_FFFF - $urandom_range(0, 31);
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    task automatic test_after_reset();
        next_chunk();
        send_item(sdcg_pkg::OP_START, 32'hFFFF_FFF0, 32'h0000_0010, 32'h20);
        next_chunk();
        next_chunk();
    endtask

    task automatic test_plain_extremes();
        send_item(sdcg_pkg::OP_START, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        next_chunk();
        send_item(sdcg_pkg::OP_START, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        next_chunk();
    endtask

    task automatic test_strided_rows();
        wait_idle();
        write_reg(sdcg_pkg::CFG_STRIDED_MODE, 32'h1);
        write_reg(sdcg_pkg::CFG_SOURCE_ROW_BYTES, 32'd3);
        write_reg(sdcg_pkg::CFG_DEST_ROW_BYTES, 32'd5);
        write_reg(sdcg_pkg::CFG_SOURCE_PITCH, 32'd16);
        write_reg(sdcg_pkg::CFG_DEST_PITCH, 32'hFFFF_FFF8);
        cfg_valid <= 1'b0;
        send_item(sdcg_pkg::OP_START, 32'h100, 32'h200, 32'd11);
        repeat (5) next_chunk();
    endtask

    task automatic test_zero_width();
        wait_idle();
        write_reg(sdcg_pkg::CFG_SOURCE_ROW_BYTES, 32'hFF00_0000);
        write_reg(sdcg_pkg::CFG_DEST_ROW_BYTES, 32'h00FF_FFFF);
        write_reg(sdcg_pkg::CFG_SOURCE_PITCH, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_INDEX, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        send_item(sdcg_pkg::OP_START, 32'hFFFF_FFFE, 32'h10, 32'd3);
        repeat (3) next_chunk();
    endtask

    task automatic test_row_shrink();
        wait_idle();
        write_reg(sdcg_pkg::CFG_SOURCE_ROW_BYTES, 32'd8);
        write_reg(sdcg_pkg::CFG_DEST_ROW_BYTES, 32'd6);
        write_reg(sdcg_pkg::CFG_SOURCE_PITCH, 32'd8);
        write_reg(sdcg_pkg::CFG_DEST_PITCH, 32'd8);
        cfg_valid <= 1'b0;
        send_item(sdcg_pkg::OP_START, 32'h40, 32'h80, 32'd20);
        repeat (3) next_chunk();
        // source row is mid-way, shrink it below the current offset
        wait_idle();
        write_reg(sdcg_pkg::CFG_SOURCE_ROW_BYTES, 32'd3);
        cfg_valid <= 1'b0;
        repeat (2) next_chunk();
    endtask

    task automatic test_random();
        int phase;
        int sent;
        int k;
        int pick;
        logic [sdcg_pkg::ADDR_W-1:0] nb;
        logic mode_bit;
        for (phase = 0; phase < 10; phase++)
        begin
            idle_on = (phase < 8) && (phase != 3);
            wait_idle();
            mode_bit = (phase % 4 == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            write_reg(sdcg_pkg::CFG_STRIDED_MODE, {31'($urandom), mode_bit});
            write_reg(sdcg_pkg::CFG_SOURCE_ROW_BYTES, rand_width());
            write_reg(sdcg_pkg::CFG_DEST_ROW_BYTES, rand_width());
            write_reg(sdcg_pkg::CFG_SOURCE_PITCH, rand_pitch());
            write_reg(sdcg_pkg::CFG_DEST_PITCH, rand_pitch());
            cfg_valid <= 1'b0;
            sent = 0;
            while (sent < 100)
            begin
                if ($urandom_range(0, 6) != 0)
                begin
                    pick = $urandom_range(0, 9);
                    case (pick)
                        0:       nb = '0;
                        1:       nb = $urandom;
                        2:       nb = $urandom_range(0, 65535);
                        default: nb = $urandom_range(1, 64);
                    endcase
                    send_item(sdcg_pkg::OP_START, rand_addr(), rand_addr(), nb);
                    k = $urandom_range(1, 12);
                    repeat (k) next_chunk();
                    sent += k + 1;
                end
                else
                begin
                    send_item(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
                    sent++;
                end
            end
        end
    endtask

    // out side backpressure in random bursts
    initial
    begin
        int run;
        forever
        begin
            @(posedge clk);
            run = $urandom_range(1, 9);
            if (idle_on && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
            repeat (run - 1) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        chunk_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_chunks.size() == 0)
            begin
                report("result with nothing expected");
            end
            else
            begin
                want = pending_chunks.pop_front();
                check_field("chunk_source", chunk_source, want.src_addr);
                check_field("chunk_dest", chunk_dest, want.dst_addr);
                check_field("chunk_bytes", chunk_bytes, want.len);
                check_field("final_chunk", 32'(final_chunk), 32'(want.last));
                check_field("idle_flag", 32'(idle_flag), 32'(want.idle));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        op          <= sdcg_pkg::OP_NEXT;
        source_base <= '0;
        dest_base   <= '0;
        total_bytes <= '0;
        out_stall   <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= sdcg_pkg::CFG_STRIDED_MODE;
        cfg_data    <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_after_reset();
        test_plain_extremes();
        test_strided_rows();
        test_zero_width();
        test_row_shrink();
        test_random();
        idle_on = 1'b0;
        wait_idle();
        repeat (8) @(posedge clk);
        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
